// File: hdl/gda_pkg.sv
// Shared types, codes and calendar constants for the Gregorian date advance block.
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [13:0] CENTURY      = 14'd100;
    localparam logic [6:0]  CENT_LAST    = 7'd99;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [4:0]  FEB_LEAP     = 5'd29;
    localparam logic [4:0]  FEB_COMMON   = 5'd28;
    localparam logic [4:0]  DAY_DEFAULT  = 5'd31;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LOAD = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } state_t;

    // Held date plus the year split into remainder and quotient (mod 4) by 100.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  cent_rem;
        logic [1:0]  cent_q;
    } cal_state_t;

    typedef struct packed {
        logic       done;
        logic [6:0] rem;
        logic [1:0] q_mod4;
    } div_result_t;

    typedef struct packed {
        logic       finish;
        logic [1:0] status;
    } step_status_t;

    function automatic logic is_leap(input logic [1:0] year_lo, input logic [6:0] cent_rem,
                                     input logic [1:0] cent_q);
        return (year_lo == 2'b00) && ((cent_rem != 7'd0) || (cent_q == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month < 4'd1 || month > MONTH_LAST) begin
            return DAY_DEFAULT;
        end
        if (month == MONTH_FEB) begin
            return leap ? FEB_LEAP : FEB_COMMON;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage
`default_nettype wire

// File: hdl/gda_cent_div.sv
// Iterative divide of a year by 100: one subtraction per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gda_cent_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [13:0]       year,
    output gda_pkg::div_result_t   result
);

    logic [13:0] rem_reg, rem_next;
    logic [1:0]  q_reg, q_next;
    logic        busy_reg, busy_next;
    logic        below;

    assign below = rem_reg < gda_pkg::CENTURY;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = year;
            q_next    = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (below) begin
                busy_next = 1'b0;
            end else begin
                rem_next = rem_reg - gda_pkg::CENTURY;
                q_next   = q_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign result.done   = busy_reg && below;
    assign result.rem    = rem_reg[6:0];
    assign result.q_mod4 = q_reg;

endmodule
`default_nettype wire

// File: hdl/gda_walk_step.sv
// One month step of the day-count walk: finish inside the month or roll to the next.
`timescale 1ns / 1ps
`default_nettype none
module gda_walk_step (
    input  gda_pkg::cal_state_t   cur,
    input  wire logic [15:0]      count,
    output gda_pkg::cal_state_t   nxt,
    output logic [15:0]           count_next,
    output gda_pkg::step_status_t stat
);

    logic        leap;
    logic [4:0]  dim;
    logic [16:0] sum;
    logic [4:0]  span;

    assign leap = gda_pkg::is_leap(cur.year[1:0], cur.cent_rem, cur.cent_q);
    assign dim  = gda_pkg::month_len(cur.month, leap);
    assign sum  = {1'b0, count} + {12'd0, cur.day};
    assign span = (dim - cur.day) + 5'd1;

    always_comb begin
        nxt         = cur;
        count_next  = count;
        stat.finish = 1'b0;
        stat.status = gda_pkg::STATUS_OK;
        if (count == 16'd0) begin
            stat.finish = 1'b1;
        end else if (sum <= {12'd0, dim}) begin
            nxt.day     = sum[4:0];
            stat.finish = 1'b1;
        end else begin
            // Consume the rest of this month and move to day 1 of the next.
            count_next = count - {11'd0, span};
            nxt.day    = 5'd1;
            if (cur.month >= gda_pkg::MONTH_LAST) begin
                if (cur.year >= gda_pkg::YEAR_MAX) begin
                    nxt.year    = gda_pkg::YEAR_MAX;
                    nxt.month   = gda_pkg::MONTH_LAST;
                    nxt.day     = gda_pkg::DAY_DEFAULT;
                    stat.finish = 1'b1;
                    stat.status = gda_pkg::STATUS_OVERFLOW;
                end else begin
                    nxt.year  = cur.year + 14'd1;
                    nxt.month = 4'd1;
                    if (cur.cent_rem == gda_pkg::CENT_LAST) begin
                        nxt.cent_rem = 7'd0;
                        nxt.cent_q   = cur.cent_q + 2'd1;
                    end else begin
                        nxt.cent_rem = cur.cent_rem + 7'd1;
                    end
                end
            end else begin
                nxt.month = cur.month + 4'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/gregorian_date_advance_top.sv
// Top level: sequencer, held date and result register of the Gregorian date advance block.
// Load: accept, divide the year by 100 by repeated subtraction, check, then output.
// Advance: accept, one walk step per month crossed plus one, then output; the month
// walk runs through the step unit. The output step waits while a result is still held.
// One transaction at a time: s_ready is high only while the sequencer is idle.
// Synchronous active-low reset sets the date to 2000-01-01 and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_advance_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [13:0] s_load_year,
    input  wire logic [3:0]  s_load_month,
    input  wire logic [4:0]  s_load_day,
    input  wire logic [15:0] s_day_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [13:0]      m_year_now,
    output logic [3:0]       m_month_now,
    output logic [4:0]       m_day_now,
    output logic [1:0]       m_status
);

    gda_pkg::state_t     state_reg, state_next;
    gda_pkg::cal_state_t cal_reg, cal_next;
    logic [13:0]         ld_year_reg;
    logic [3:0]          ld_month_reg;
    logic [4:0]          ld_day_reg;
    logic [15:0]         count_reg, count_next;
    logic [1:0]          status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [13:0]         m_year_reg;
    logic [3:0]          m_month_reg;
    logic [4:0]          m_day_reg;
    logic [1:0]          m_status_reg;

    logic                  accept;
    logic                  div_start;
    gda_pkg::div_result_t  div_res;
    gda_pkg::cal_state_t   step_cal;
    logic [15:0]           step_count;
    gda_pkg::step_status_t step_stat;
    logic                  ld_leap;
    logic                  ld_bad;
    logic                  out_free;
    logic                  out_load;

    assign accept    = s_valid && s_ready;
    assign div_start = accept && (s_kind == gda_pkg::KIND_LOAD);
    assign out_free  = !m_valid_reg || m_ready;

    gda_cent_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .year    (s_load_year),
        .result  (div_res)
    );

    gda_walk_step u_step (
        .cur        (cal_reg),
        .count      (count_reg),
        .nxt        (step_cal),
        .count_next (step_count),
        .stat       (step_stat)
    );

    assign ld_leap = gda_pkg::is_leap(ld_year_reg[1:0], div_res.rem, div_res.q_mod4);

    always_comb begin
        ld_bad = (ld_year_reg > gda_pkg::YEAR_MAX)
              || !(ld_month_reg inside {[4'd1:gda_pkg::MONTH_LAST]})
              || (ld_day_reg == 5'd0)
              || (ld_day_reg > gda_pkg::month_len(ld_month_reg, ld_leap));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gda_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_kind == gda_pkg::KIND_LOAD) ? gda_pkg::ST_DIV
                                                                 : gda_pkg::ST_WALK;
                end
            end
            gda_pkg::ST_DIV: begin
                if (div_res.done) begin
                    state_next = gda_pkg::ST_CHECK;
                end
            end
            gda_pkg::ST_CHECK: begin
                state_next = gda_pkg::ST_DONE;
            end
            gda_pkg::ST_WALK: begin
                if (step_stat.finish) begin
                    state_next = gda_pkg::ST_DONE;
                end
            end
            gda_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = gda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready     = 1'b0;
        out_load    = 1'b0;
        cal_next    = cal_reg;
        count_next  = count_reg;
        status_next = status_reg;
        case (state_reg)
            gda_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                count_next  = s_day_count;
                status_next = gda_pkg::STATUS_OK;
            end
            gda_pkg::ST_CHECK: begin
                if (ld_bad) begin
                    status_next = gda_pkg::STATUS_BAD_LOAD;
                end else begin
                    cal_next.year     = ld_year_reg;
                    cal_next.month    = ld_month_reg;
                    cal_next.day      = ld_day_reg;
                    cal_next.cent_rem = div_res.rem;
                    cal_next.cent_q   = div_res.q_mod4;
                end
            end
            gda_pkg::ST_WALK: begin
                cal_next    = step_cal;
                count_next  = step_count;
                status_next = step_stat.status;
            end
            gda_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= gda_pkg::ST_IDLE;
            cal_reg.year     <= 14'd2000;
            cal_reg.month    <= 4'd1;
            cal_reg.day      <= 5'd1;
            cal_reg.cent_rem <= 7'd0;
            cal_reg.cent_q   <= 2'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cal_reg     <= cal_next;
            m_valid_reg <= m_valid_next;
        end
        count_reg  <= count_next;
        status_reg <= status_next;
        if (accept) begin
            ld_year_reg  <= s_load_year;
            ld_month_reg <= s_load_month;
            ld_day_reg   <= s_load_day;
        end
        if (out_load) begin
            m_year_reg   <= cal_reg.year;
            m_month_reg  <= cal_reg.month;
            m_day_reg    <= cal_reg.day;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_year_now  = m_year_reg;
    assign m_month_now = m_month_reg;
    assign m_day_now   = m_day_reg;
    assign m_status    = m_status_reg;

endmodule
`default_nettype wire
